// File: rtl/chained_hash_key_value_store_defines.svh
// ----------------------------------------------------------------------------
// chained hash key-value store: assertion macros
// immediate-consequence and next-cycle property forms on clk / arst_n
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_KEY_VALUE_STORE_DEFINES_SVH
`define CHAINED_HASH_KEY_VALUE_STORE_DEFINES_SVH

// consequence in the same cycle
`define CHKV_ASSERT_SAME(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("chkv: property violated");

// consequence in the next cycle
`define CHKV_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("chkv: property violated");

`endif

// File: rtl/chkv_pkg.sv
// ----------------------------------------------------------------------------
// chkv_pkg
// shared constants, codes, command/status structs and value arithmetic
// ----------------------------------------------------------------------------
package chkv_pkg;

	localparam int KEY_BITS     = 32;
	localparam int VALUE_BITS   = 32;
	localparam int BUCKETS_DEF  = 256;
	localparam int NODES_DEF    = 256;
	localparam int HASH_BITS    = 31;
	localparam int BCNT_BITS    = 9;
	localparam int CFG_BITS     = 31;
	localparam int CFG_IDX_BITS = 2;
	localparam int DVD_BITS     = 64;
	localparam int DIV_STEPS    = 64;

	// request modes
	localparam logic [2:0] MODE_INSERT    = 3'd0;
	localparam logic [2:0] MODE_REMOVE    = 3'd1;
	localparam logic [2:0] MODE_LOOKUP    = 3'd2;
	localparam logic [2:0] MODE_ADD       = 3'd3;
	localparam logic [2:0] MODE_SET       = 3'd4;
	localparam logic [2:0] MODE_SET_ALL   = 3'd5;
	localparam logic [2:0] MODE_CLEAR_ALL = 3'd6;

	// result status
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_POOL_FULL = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_MULT_A       = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ADD_B        = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PRIME        = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_BUCKET_COUNT = 2'd3;

	localparam logic [HASH_BITS-1:0] MULT_A_RST = 31'd1;
	localparam logic [HASH_BITS-1:0] ADD_B_RST  = 31'd0;
	localparam logic [HASH_BITS-1:0] PRIME_RST  = 31'h7FFF_FFFF;
	localparam logic [BCNT_BITS-1:0] BCNT_RST   = 9'd256;

	localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	typedef struct packed {
		logic load;
		logic div_start_p;
		logic div_start_m;
		logic clear_wr;
		logic head_rd;
		logic head_load;
		logic node_rd;
		logic hit;
		logic walk_next;
		logic resolve;
		logic link_wr;
		logic sweep_wr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic       clear_last;
		logic       p_zero;
		logic       div_done;
		logic       cur_null;
		logic       key_match;
		logic       free_done;
		logic       need_link;
		logic       sweep_last;
		logic       out_free;
		logic [2:0] mode;
	} sts_t;

	function automatic logic signed [VALUE_BITS-1:0] sat_add(
		input logic signed [VALUE_BITS-1:0] x,
		input logic signed [VALUE_BITS-1:0] y
	);
		logic [VALUE_BITS:0] s;
		s = {x[VALUE_BITS-1], x} + {y[VALUE_BITS-1], y};
		if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
			return s[VALUE_BITS] ? VAL_MIN : VAL_MAX;
		end
		return s[VALUE_BITS-1:0];
	endfunction

endpackage

// File: rtl/chkv_ram.sv
// ----------------------------------------------------------------------------
// chkv_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module chkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/chkv_div.sv
// ----------------------------------------------------------------------------
// chkv_div
// radix-2 restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module chkv_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [chkv_pkg::DVD_BITS-1:0]      dividend,
	input  logic [chkv_pkg::HASH_BITS-1:0]     divisor,
	output logic                               done,
	output logic [chkv_pkg::HASH_BITS-1:0]     rem
);

	localparam int CW = $clog2(chkv_pkg::DIV_STEPS + 1);
	localparam int HB = chkv_pkg::HASH_BITS;
	localparam int DB = chkv_pkg::DVD_BITS;

	logic [CW-1:0] cnt_q;
	logic [DB-1:0] dvd_q;
	logic [HB-1:0] rem_q;
	logic [HB-1:0] dvs_q;
	logic [HB:0]   trial;
	logic          ge;

	assign trial = {rem_q, dvd_q[DB-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign done  = (cnt_q == '0);
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(chkv_pkg::DIV_STEPS);
		end else if (!done) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (!done) begin
			dvd_q <= {dvd_q[DB-2:0], 1'b0};
			rem_q <= ge ? HB'(trial - {1'b0, dvs_q}) : HB'(trial);
		end
	end

endmodule

// File: rtl/chkv_ctrl.sv
// ----------------------------------------------------------------------------
// chkv_ctrl
// request sequencer: clearing pass, hashing, chain walk, update, result
// ----------------------------------------------------------------------------
module chkv_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  chkv_pkg::sts_t  sts,
	output chkv_pkg::cmd_t  cmd
);

	typedef enum logic [13:0] {
		S_CLEAR   = 14'b00000000000001,
		S_IDLE    = 14'b00000000000010,
		S_MUL     = 14'b00000000000100,
		S_DIVP    = 14'b00000000001000,
		S_DIVM    = 14'b00000000010000,
		S_HEAD    = 14'b00000000100000,
		S_HLOAD   = 14'b00000001000000,
		S_WALK    = 14'b00000010000000,
		S_CMP     = 14'b00000100000000,
		S_FREE    = 14'b00001000000000,
		S_RESOLVE = 14'b00010000000000,
		S_LINK    = 14'b00100000000000,
		S_SWEEP   = 14'b01000000000000,
		S_DONE    = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				if (sts.mode == chkv_pkg::MODE_SET_ALL ||
				    sts.mode == chkv_pkg::MODE_CLEAR_ALL) begin
					state_d = S_SWEEP;
				end else if (sts.mode > chkv_pkg::MODE_CLEAR_ALL) begin
					state_d = S_DONE;
				end else if (sts.p_zero) begin
					cmd.div_start_m = 1'b1;
					state_d         = S_DIVM;
				end else begin
					cmd.div_start_p = 1'b1;
					state_d         = S_DIVP;
				end
			end
			S_DIVP: begin
				if (sts.div_done) begin
					cmd.div_start_m = 1'b1;
					state_d         = S_DIVM;
				end
			end
			S_DIVM: begin
				if (sts.div_done) state_d = S_HEAD;
			end
			S_HEAD: begin
				cmd.head_rd = 1'b1;
				state_d     = S_HLOAD;
			end
			S_HLOAD: begin
				cmd.head_load = 1'b1;
				state_d       = S_WALK;
			end
			S_WALK: begin
				if (sts.cur_null) begin
					state_d = S_FREE;
				end else begin
					cmd.node_rd = 1'b1;
					state_d     = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.key_match) begin
					cmd.hit = 1'b1;
					state_d = S_FREE;
				end else begin
					cmd.walk_next = 1'b1;
					state_d       = S_WALK;
				end
			end
			S_FREE: begin
				if (sts.free_done) state_d = S_RESOLVE;
			end
			S_RESOLVE: begin
				cmd.resolve = 1'b1;
				state_d     = sts.need_link ? S_LINK : S_DONE;
			end
			S_LINK: begin
				cmd.link_wr = 1'b1;
				state_d     = S_DONE;
			end
			S_SWEEP: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/chkv_dp.sv
// ----------------------------------------------------------------------------
// chkv_dp
// datapath: config registers, hash, node pool memories, free scan, result
// ----------------------------------------------------------------------------
module chkv_dp #(
	parameter int BUCKETS = chkv_pkg::BUCKETS_DEF,
	parameter int NODES   = chkv_pkg::NODES_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [chkv_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [chkv_pkg::CFG_BITS-1:0]            cfg_data,
	input  logic [2:0]                               mode,
	input  logic [chkv_pkg::KEY_BITS-1:0]            key,
	input  logic signed [chkv_pkg::VALUE_BITS-1:0]   value,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [chkv_pkg::VALUE_BITS-1:0]   read_value,
	output logic                                     found,
	output logic [1:0]                               status,
	input  chkv_pkg::cmd_t                           cmd,
	output chkv_pkg::sts_t                           sts
);

	localparam int PW  = $clog2(NODES + 1);
	localparam int NIW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int BIW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int HB  = chkv_pkg::HASH_BITS;
	localparam int KB  = chkv_pkg::KEY_BITS;
	localparam int VB  = chkv_pkg::VALUE_BITS;
	localparam int DB  = chkv_pkg::DVD_BITS;
	localparam logic [PW-1:0] NULL_PTR = PW'(NODES);

	// configuration
	logic [HB-1:0]                    mult_a_q, add_b_q, prime_q;
	logic [chkv_pkg::BCNT_BITS-1:0]   bcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_a_q <= chkv_pkg::MULT_A_RST;
			add_b_q  <= chkv_pkg::ADD_B_RST;
			prime_q  <= chkv_pkg::PRIME_RST;
			bcnt_q   <= chkv_pkg::BCNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				chkv_pkg::REG_MULT_A:       mult_a_q <= cfg_data;
				chkv_pkg::REG_ADD_B:        add_b_q  <= cfg_data;
				chkv_pkg::REG_PRIME:        prime_q  <= cfg_data;
				chkv_pkg::REG_BUCKET_COUNT: bcnt_q   <= cfg_data[chkv_pkg::BCNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// request registers
	logic [2:0]           mode_q;
	logic [KB-1:0]        key_q;
	logic signed [VB-1:0] val_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			key_q  <= key;
			val_q  <= value;
		end
	end

	// hash: product plus offset, then two remainders in the shared unit (one when the prime is zero)
	logic [DB-1:0] hash_c;
	logic [31:0]   bc32;
	logic [HB-1:0] m_eff;
	logic [DB-1:0] div_dvd;
	logic [HB-1:0] div_dvs;
	logic          div_done;
	logic [HB-1:0] div_rem;

	assign hash_c = DB'(DB'(mult_a_q) * DB'(key_q)) + DB'(add_b_q);
	assign bc32   = 32'(bcnt_q);

	always_comb begin
		if (bc32 == 32'd0) begin
			m_eff = HB'(1);
		end else if (bc32 > 32'(BUCKETS)) begin
			m_eff = HB'(BUCKETS);
		end else begin
			m_eff = HB'(bcnt_q);
		end
	end

	assign div_dvd = (cmd.div_start_p || prime_q == '0) ? hash_c : DB'(div_rem);
	assign div_dvs = cmd.div_start_p ? prime_q : m_eff;

	chkv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start_p | cmd.div_start_m),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.rem      (div_rem)
	);

	// node usage flags and lowest-free scan, one node a cycle
	logic [NODES-1:0] used_q;
	logic [PW-1:0]    free_q;
	logic             scan_q;
	logic [NIW-1:0]   free_idx;

	assign free_idx = free_q[NIW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= 1'b0;
			free_q <= '0;
		end else if (cmd.load) begin
			scan_q <= 1'b1;
			free_q <= '0;
		end else if (scan_q) begin
			if (free_q == NULL_PTR || !used_q[free_idx]) begin
				scan_q <= 1'b0;
			end else begin
				free_q <= free_q + 1'b1;
			end
		end
	end

	// chain walk registers
	logic [BIW-1:0] b_q;
	logic [PW-1:0]  cur_q, prev_q;
	logic           found_q;
	logic [NIW-1:0] cur_idx, prev_idx;
	logic           prev_null, free_ok;

	logic [PW-1:0]  head_rdata;
	logic [KB-1:0]  key_rdata;
	logic [VB-1:0]  val_rdata;
	logic [PW-1:0]  link_rdata;

	assign cur_idx   = cur_q[NIW-1:0];
	assign prev_idx  = prev_q[NIW-1:0];
	assign prev_null = (prev_q == NULL_PTR);
	assign free_ok   = (free_q != NULL_PTR);

	always_ff @(posedge clk) begin
		if (cmd.head_rd) begin
			b_q <= div_rem[BIW-1:0];
		end
		if (cmd.head_load) begin
			cur_q  <= head_rdata;
			prev_q <= NULL_PTR;
		end else if (cmd.walk_next) begin
			prev_q <= cur_q;
			cur_q  <= link_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.load) begin
			found_q <= 1'b0;
		end else if (cmd.hit) begin
			found_q <= 1'b1;
		end
	end

	// clearing pass and set-all / clear-all sweep counters
	logic [BIW-1:0] clr_q;
	logic [NIW-1:0] sw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			sw_q  <= '0;
		end else begin
			if (cmd.clear_wr) clr_q <= clr_q + 1'b1;
			if (cmd.load) begin
				sw_q <= '0;
			end else if (cmd.sweep_wr) begin
				sw_q <= sw_q + 1'b1;
			end
		end
	end

	// memory write ports and result
	logic                 head_we, key_we, val_we, link_we;
	logic [BIW-1:0]       head_wa;
	logic [PW-1:0]        head_wd;
	logic [NIW-1:0]       key_wa, val_wa, link_wa;
	logic [VB-1:0]        val_wd;
	logic [PW-1:0]        link_wd;
	logic signed [VB-1:0] sum_c;
	logic signed [VB-1:0] rv_d;
	logic [1:0]           st_d;

	assign sum_c = chkv_pkg::sat_add(val_rdata, val_q);

	always_comb begin
		head_we = 1'b0; head_wa = b_q;     head_wd = NULL_PTR;
		key_we  = 1'b0; key_wa  = free_idx;
		val_we  = 1'b0; val_wa  = cur_idx; val_wd  = val_q;
		link_we = 1'b0; link_wa = free_idx; link_wd = NULL_PTR;
		rv_d    = '0;
		st_d    = chkv_pkg::ST_OK;
		if (cmd.clear_wr) begin
			head_we = 1'b1;
			head_wa = clr_q;
		end
		if (cmd.sweep_wr) begin
			val_we = used_q[sw_q];
			val_wa = sw_q;
			val_wd = (mode_q == chkv_pkg::MODE_SET_ALL) ? val_q : '0;
		end
		if (cmd.link_wr) begin
			link_we = 1'b1;
			link_wa = prev_idx;
			link_wd = free_q;
		end
		if (cmd.resolve) begin
			case (mode_q)
				chkv_pkg::MODE_INSERT: begin
					if (found_q) begin
						val_we = 1'b1;
						rv_d   = val_q;
					end else if (!free_ok) begin
						st_d = chkv_pkg::ST_POOL_FULL;
					end else begin
						key_we  = 1'b1;
						val_we  = 1'b1;
						val_wa  = free_idx;
						link_we = 1'b1;
						head_we = prev_null;
						head_wd = free_q;
						rv_d    = val_q;
					end
				end
				chkv_pkg::MODE_REMOVE: begin
					if (!found_q) begin
						st_d = chkv_pkg::ST_NOT_FOUND;
					end else begin
						head_we = prev_null;
						head_wd = link_rdata;
						link_we = !prev_null;
						link_wa = prev_idx;
						link_wd = link_rdata;
					end
				end
				chkv_pkg::MODE_LOOKUP: begin
					if (!found_q) st_d = chkv_pkg::ST_NOT_FOUND;
					else rv_d = val_rdata;
				end
				chkv_pkg::MODE_ADD: begin
					if (!found_q) begin
						st_d = chkv_pkg::ST_NOT_FOUND;
					end else begin
						val_we = 1'b1;
						val_wd = sum_c;
						rv_d   = sum_c;
					end
				end
				chkv_pkg::MODE_SET: begin
					if (!found_q) begin
						st_d = chkv_pkg::ST_NOT_FOUND;
					end else begin
						val_we = 1'b1;
						rv_d   = val_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.resolve && found_q == 1'b0 && free_ok &&
		             mode_q == chkv_pkg::MODE_INSERT) begin
			used_q[free_idx] <= 1'b1;
		end else if (cmd.resolve && found_q && mode_q == chkv_pkg::MODE_REMOVE) begin
			used_q[cur_idx] <= 1'b0;
		end
	end

	chkv_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head (
		.clk (clk), .we (head_we), .waddr (head_wa), .wdata (head_wd),
		.re (cmd.head_rd), .raddr (div_rem[BIW-1:0]), .rdata (head_rdata)
	);

	chkv_ram #(.WIDTH(KB), .DEPTH(NODES)) u_key (
		.clk (clk), .we (key_we), .waddr (key_wa), .wdata (key_q),
		.re (cmd.node_rd), .raddr (cur_idx), .rdata (key_rdata)
	);

	chkv_ram #(.WIDTH(VB), .DEPTH(NODES)) u_val (
		.clk (clk), .we (val_we), .waddr (val_wa), .wdata (val_wd),
		.re (cmd.node_rd), .raddr (cur_idx), .rdata (val_rdata)
	);

	chkv_ram #(.WIDTH(PW), .DEPTH(NODES)) u_link (
		.clk (clk), .we (link_we), .waddr (link_wa), .wdata (link_wd),
		.re (cmd.node_rd), .raddr (cur_idx), .rdata (link_rdata)
	);

	// result and output registers
	logic signed [VB-1:0] res_val_q, out_val_q;
	logic                 res_fnd_q, out_fnd_q;
	logic [1:0]           res_st_q, out_st_q;
	logic                 out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_val_q <= '0;
			res_fnd_q <= 1'b0;
			res_st_q  <= chkv_pkg::ST_OK;
		end else if (cmd.resolve) begin
			res_val_q <= rv_d;
			res_fnd_q <= found_q;
			res_st_q  <= st_d;
		end
		if (cmd.out_load) begin
			out_val_q <= res_val_q;
			out_fnd_q <= res_fnd_q;
			out_st_q  <= res_st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = out_val_q;
	assign found      = out_fnd_q;
	assign status     = out_st_q;

	// status to the controller
	assign sts.clear_last = (clr_q == BIW'(BUCKETS - 1));
	assign sts.p_zero     = (prime_q == '0);
	assign sts.div_done   = div_done;
	assign sts.cur_null   = (cur_q == NULL_PTR);
	assign sts.key_match  = (key_rdata == key_q);
	assign sts.free_done  = !scan_q;
	assign sts.need_link  = (mode_q == chkv_pkg::MODE_INSERT) && !found_q && free_ok &&
	                        !prev_null;
	assign sts.sweep_last = (sw_q == NIW'(NODES - 1));
	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.mode       = mode_q;

endmodule

// File: rtl/chained_hash_key_value_store.sv
// ----------------------------------------------------------------------------
// chained_hash_key_value_store
// key-value store over a universal hash with bucket chains in a node pool
// ----------------------------------------------------------------------------
// sequence: a keyed item has its hash reduced by two remainder passes (one
//   pass with a zero prime modulus), reads its bucket head, walks the chain,
//   waits for the free-node scan, then resolves, and links a new node when one
//   is added behind another; set all / clear all sweep the node pool instead
// throughput: one item at a time, the next item is taken while a result
//   waits; reset: async, active low, then a clearing pass empties the bucket
//   heads, no item taken
module chained_hash_key_value_store #(
	parameter int BUCKETS = chkv_pkg::BUCKETS_DEF,
	parameter int NODES   = chkv_pkg::NODES_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// register write port
	input  logic                                     cfg_we,
	input  logic [chkv_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [chkv_pkg::CFG_BITS-1:0]            cfg_data,
	// request channel
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [2:0]                               mode,
	input  logic [chkv_pkg::KEY_BITS-1:0]            key,
	input  logic signed [chkv_pkg::VALUE_BITS-1:0]   value,
	// result channel
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [chkv_pkg::VALUE_BITS-1:0]   read_value,
	output logic                                     found,
	output logic [1:0]                               status
);

	chkv_pkg::cmd_t cmd;
	chkv_pkg::sts_t sts;

	// sequencer: owns the request handshake and orders every step
	chkv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: registers, hash unit, memories and output register
	chkv_dp #(
		.BUCKETS (BUCKETS),
		.NODES   (NODES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mode       (mode),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_value (read_value),
		.found      (found),
		.status     (status),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

// File: rtl/chkv_checker.sv
// ----------------------------------------------------------------------------
// chkv_checker
// port-level checks of the key-value store, bound to the top level
// ----------------------------------------------------------------------------
`include "chained_hash_key_value_store_defines.svh"

module chkv_checker (
	input logic                                     clk,
	input logic                                     arst_n,
	input logic                                     in_valid,
	input logic                                     in_ready,
	input logic                                     out_valid,
	input logic                                     out_ready,
	input logic signed [chkv_pkg::VALUE_BITS-1:0]   read_value,
	input logic                                     found,
	input logic [1:0]                               status
);

	// a stalled result holds
	`CHKV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_value))

	// one item in work at a time
	`CHKV_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

	// failed requests report a zero value
	`CHKV_ASSERT_SAME(a_fail_zero, out_valid && status != chkv_pkg::ST_OK, read_value == '0)

	// a missing key or full pool never reports found
	`CHKV_ASSERT_SAME(a_fail_nofound, out_valid && status != chkv_pkg::ST_OK, !found)

endmodule

bind chained_hash_key_value_store chkv_checker u_chkv_checker (.*);

// File: dv/chkv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chkv_tb_checker
// watches the register port and both channels, predicts each result and
// compares it field by field in order
// ----------------------------------------------------------------------------
module chkv_tb_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [chkv_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [chkv_pkg::CFG_BITS-1:0]          cfg_data,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic [2:0]                             mode,
	input  logic [chkv_pkg::KEY_BITS-1:0]          key,
	input  logic signed [chkv_pkg::VALUE_BITS-1:0] value,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic signed [chkv_pkg::VALUE_BITS-1:0] read_value,
	input  logic                                   found,
	input  logic [1:0]                             status,
	output int                                     errors,
	output int                                     pending
);
	import chkv_pkg::*;

	localparam int NBUCKET = BUCKETS_DEF;
	localparam int NNODE   = NODES_DEF;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] rv;
		logic                         fnd;
		logic [1:0]                   st;
	} lookup_res_t;

	lookup_res_t res_q[$];

	logic [HASH_BITS-1:0]         hash_mult, hash_add, hash_prime;
	logic [BCNT_BITS-1:0]         n_buckets;
	int                           head_of[NBUCKET];
	logic [KEY_BITS-1:0]          slot_key[NNODE];
	logic signed [VALUE_BITS-1:0] slot_val[NNODE];
	int                           slot_next[NNODE];
	bit                           slot_busy[NNODE];

	function automatic int bucket_index(logic [KEY_BITS-1:0] k);
		logic [63:0] h;
		logic [63:0] m;
		h = {33'd0, hash_mult} * {32'd0, k} + {33'd0, hash_add};
		m = {55'd0, n_buckets};
		if (m == 0) m = 1;
		if (m > NBUCKET) m = NBUCKET;
		if (hash_prime != 0) h = h % {33'd0, hash_prime};
		return int'(h % m);
	endfunction

	function automatic logic signed [VALUE_BITS-1:0] add_clamped(
		logic signed [VALUE_BITS-1:0] x, logic signed [VALUE_BITS-1:0] y);
		longint s;
		s = longint'(x) + longint'(y);
		if (s > longint'(VAL_MAX)) return VAL_MAX;
		if (s < longint'(VAL_MIN)) return VAL_MIN;
		return s[VALUE_BITS-1:0];
	endfunction

	function automatic lookup_res_t apply_request(logic [2:0] md, logic [KEY_BITS-1:0] k,
		logic signed [VALUE_BITS-1:0] v);
		lookup_res_t r;
		int b, prv, cur, steps, fr;
		r = '0;
		if (md <= MODE_SET) begin
			b = bucket_index(k);
			prv = NNODE;
			cur = head_of[b];
			for (steps = 0; steps < NNODE && cur < NNODE; steps++) begin
				if (slot_key[cur] == k) break;
				prv = cur;
				cur = slot_next[cur];
			end
			if (cur > NNODE) cur = NNODE;
			r.fnd = (cur < NNODE);
			if (md == MODE_INSERT) begin
				if (cur < NNODE) begin
					slot_val[cur] = v;
					r.rv = v;
				end else begin
					for (fr = 0; fr < NNODE && slot_busy[fr]; fr++) ;
					if (fr >= NNODE) begin
						r.st = ST_POOL_FULL;
					end else begin
						slot_busy[fr] = 1;
						slot_key[fr] = k;
						slot_val[fr] = v;
						slot_next[fr] = NNODE;
						if (prv < NNODE) slot_next[prv] = fr;
						else head_of[b] = fr;
						r.rv = v;
					end
				end
			end else if (cur >= NNODE) begin
				r.st = ST_NOT_FOUND;
			end else if (md == MODE_REMOVE) begin
				if (prv < NNODE) slot_next[prv] = slot_next[cur];
				else head_of[b] = slot_next[cur];
				slot_busy[cur] = 0;
			end else begin
				if (md == MODE_ADD) slot_val[cur] = add_clamped(slot_val[cur], v);
				else if (md == MODE_SET) slot_val[cur] = v;
				r.rv = slot_val[cur];
			end
		end else if (md == MODE_SET_ALL || md == MODE_CLEAR_ALL) begin
			for (fr = 0; fr < NNODE; fr++)
				if (slot_busy[fr]) slot_val[fr] = (md == MODE_SET_ALL) ? v : '0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_res_t e;
		if (!arst_n) begin
			hash_mult  = MULT_A_RST;
			hash_add   = ADD_B_RST;
			hash_prime = PRIME_RST;
			n_buckets  = BCNT_RST;
			for (int i = 0; i < NBUCKET; i++) head_of[i] = NNODE;
			for (int i = 0; i < NNODE; i++) begin
				slot_busy[i] = 0;
				slot_key[i] = '0;
				slot_val[i] = '0;
				slot_next[i] = 0;
			end
			res_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MULT_A:       hash_mult  = cfg_data;
					REG_ADD_B:        hash_add   = cfg_data;
					REG_PRIME:        hash_prime = cfg_data;
					REG_BUCKET_COUNT: n_buckets  = cfg_data[BCNT_BITS-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (res_q.size() == 0) begin
					$display("%0t: unexpected result rv=%h found=%b status=%0d",
						$time, read_value, found, status);
					errors++;
				end else begin
					e = res_q.pop_front();
					if (e.rv !== read_value || e.fnd !== found || e.st !== status) begin
						$display("%0t: mismatch expected rv=%h found=%b status=%0d,",
							$time, e.rv, e.fnd, e.st);
						$display("%0t:   got rv=%h found=%b status=%0d",
							$time, read_value, found, status);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) res_q.push_back(apply_request(mode, key, value));
			pending = res_q.size();
		end
	end
endmodule

// File: dv/tb_chained_hash_key_value_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chained_hash_key_value_store
// directed and random requests through several hash settings and idle
// patterns; results are checked in order by chkv_tb_checker
// ----------------------------------------------------------------------------
module tb_chained_hash_key_value_store;
	import chkv_pkg::*;

	// the eighth mode code, which the block ignores
	localparam logic [2:0] MODE_UNUSED = 3'd7;
	localparam int HOLD_CYCLES = 3000;

	logic                         clk = 0;
	logic                         arst_n = 0;
	logic                         cfg_we = 0;
	logic [CFG_IDX_BITS-1:0]      cfg_index = '0;
	logic [CFG_BITS-1:0]          cfg_data = '0;
	logic                         in_valid = 0;
	logic                         in_ready;
	logic [2:0]                   mode = '0;
	logic [KEY_BITS-1:0]          key = '0;
	logic signed [VALUE_BITS-1:0] value = '0;
	logic                         out_valid;
	logic                         out_ready = 0;
	logic signed [VALUE_BITS-1:0] read_value;
	logic                         found;
	logic [1:0]                   status;
	int                           errors, pending;

	// idle percentages of each side, and the long receiver hold-off request
	int  send_gap_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_req = 0;
	int  hold_left = 0;

	// keys reused so that hits, chains and a full pool actually happen
	logic [KEY_BITS-1:0] key_pool[320];

	always #1 clk = ~clk;

	chained_hash_key_value_store dut (.*);

	chkv_tb_checker u_checker (.*);

	// receiver: random stalls, plus a long hold-off counted here
	always @(posedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left <= HOLD_CYCLES;
			out_ready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= (hold_left == 1);
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// timeout guard
	initial begin
		#40_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] d);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
	endtask

	// wait until every result is back, then let the block settle before a write
	task automatic drain;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_hash(logic [30:0] a, logic [30:0] b, logic [30:0] p, logic [8:0] m);
		drain();
		write_reg(REG_MULT_A, a);
		write_reg(REG_ADD_B, b);
		write_reg(REG_PRIME, p);
		write_reg(REG_BUCKET_COUNT, {22'd0, m});
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// offer one item and hold it until accepted; random gap first
	task automatic send(logic [2:0] md, logic [KEY_BITS-1:0] k, logic signed [VALUE_BITS-1:0] v);
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_gap_pct) @(posedge clk);
		end
		in_valid <= 1;
		mode <= md;
		key <= k;
		value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic rand_items(int count, int insert_pct, int span);
		logic [2:0]                   md;
		logic [KEY_BITS-1:0]          k;
		logic signed [VALUE_BITS-1:0] v;
		int                           r;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < insert_pct) begin
				md = MODE_INSERT;
			end else begin
				r = $urandom_range(99);
				if (r < 25)      md = MODE_REMOVE;
				else if (r < 55) md = MODE_LOOKUP;
				else if (r < 75) md = MODE_ADD;
				else if (r < 88) md = MODE_SET;
				else if (r < 92) md = MODE_SET_ALL;
				else if (r < 96) md = MODE_CLEAR_ALL;
				else             md = MODE_UNUSED;
			end
			// mostly known keys so that chains get walked and hit
			k = ($urandom_range(99) < 80) ? key_pool[$urandom_range(span - 1)] : $urandom;
			r = $urandom_range(19);
			if (r == 0)      v = VAL_MAX;
			else if (r == 1) v = VAL_MIN;
			else             v = $urandom;
			send(md, k, v);
		end
		in_valid <= 0;
		@(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < 320; i++)
			key_pool[i] = (i < 16) ? KEY_BITS'(i * 256) : $urandom;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed part on reset hashing: bucket = key mod 256 for small keys,
		// so 0, 256, 512 and 768 share a chain
		send(MODE_INSERT, 32'd0, VAL_MAX);
		send(MODE_INSERT, 32'd256, 32'sd1);
		send(MODE_INSERT, 32'd512, VAL_MIN);
		send(MODE_INSERT, 32'hFFFF_FFFF, 32'sh0001_0000);
		send(MODE_LOOKUP, 32'd256, 32'sd0);
		send(MODE_ADD, 32'd0, 32'sd1);          // saturates high
		send(MODE_ADD, 32'd512, -32'sd1);       // saturates low
		send(MODE_ADD, 32'd256, -32'sd5);
		send(MODE_SET, 32'hFFFF_FFFF, 32'sd0);
		send(MODE_INSERT, 32'd0, 32'sd7);       // update of a present key
		send(MODE_LOOKUP, 32'd999, 32'sd3);     // missing key cases
		send(MODE_ADD, 32'd999, 32'sd3);
		send(MODE_SET, 32'd999, 32'sd3);
		send(MODE_REMOVE, 32'd999, 32'sd3);
		send(MODE_REMOVE, 32'd256, 32'sd0);     // middle of the chain
		send(MODE_LOOKUP, 32'd512, 32'sd0);
		send(MODE_REMOVE, 32'd0, 32'sd0);       // head of the chain
		send(MODE_INSERT, 32'd768, 32'sh7FFF_0000);
		send(MODE_SET_ALL, 32'hFFFF_FFFF, 32'sh8000_0001);
		send(MODE_LOOKUP, 32'd768, 32'sd0);
		send(MODE_CLEAR_ALL, 32'd0, VAL_MAX);
		send(MODE_LOOKUP, 32'd512, 32'sd0);
		send(MODE_UNUSED, 32'hFFFF_FFFF, -32'sd1);
		send(MODE_REMOVE, 32'hFFFF_FFFF, 32'sd0);
		send(MODE_INSERT, 32'd0, -32'sd1);
		in_valid <= 0;
		@(posedge clk);

		// random hash, no idling
		set_hash(31'($urandom_range(2147483646, 1)), 31'($urandom), 31'h7FFF_FFFF, 9'd256);
		rand_items(250, 40, 64);

		// prime reduction skipped, one bucket; sender mostly idle
		set_hash(31'd1, 31'd0, 31'd0, 9'd1);
		send_gap_pct = 82;
		rand_items(200, 40, 64);

		// largest operands, bucket count above range; receiver stalls and
		// one long hold-off so the block backs up into its input
		set_hash(31'h7FFF_FFFE, 31'h7FFF_FFFE, 31'h7FFF_FFFF, 9'd511);
		send_gap_pct = 0;
		recv_stall_pct = 82;
		hold_req <= 1;
		rand_items(30, 40, 64);
		hold_req <= 0;
		rand_items(220, 40, 64);

		// small prime and zero bucket count; wide key set to fill the pool
		set_hash(31'($urandom), 31'($urandom), 31'd2, 9'd0);
		send_gap_pct = 33;
		recv_stall_pct = 33;
		rand_items(150, 90, 320);
		set_hash(31'($urandom_range(2147483646, 1)), 31'd0, 31'd13, 9'd7);
		rand_items(200, 85, 320);

		// random hash again, with fewer inserts and more removes
		set_hash(31'($urandom_range(2147483646, 1)), 31'($urandom), 31'd65521, 9'd37);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		rand_items(250, 25, 320);

		drain();
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
